@@ rtl/jsv_pkg.sv @@
// Shared types, codes and the literal spelling table for the JSON syntax validator.
package jsv_pkg;

	// Character classes that the front end attaches to each byte.
	typedef enum logic [3:0] {
		C_OTHER  = 4'd0,
		C_WS     = 4'd1,
		C_NL     = 4'd2,
		C_LBRACE = 4'd3,
		C_LBRACK = 4'd4,
		C_RBRACE = 4'd5,
		C_RBRACK = 4'd6,
		C_QUOTE  = 4'd7,
		C_COLON  = 4'd8,
		C_COMMA  = 4'd9,
		C_DOT    = 4'd10,
		C_BSLASH = 4'd11,
		C_ZERO   = 4'd12,
		C_DIGIT  = 4'd13,
		C_T      = 4'd14,
		C_F      = 4'd15
	} cls_t;

	// One queued byte with its class.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		cls_t       cls;
	} q_item_t;

	localparam logic [1:0] ST_PEND  = 2'd0;
	localparam logic [1:0] ST_VALID = 2'd1;
	localparam logic [1:0] ST_ERR   = 2'd2;

	localparam int STATUS_W = 2;
	localparam int POS_W    = 25;
	localparam int DEPTH_W  = 7;
	localparam int TDATA_W  = 40;

	localparam logic KIND_OBJ = 1'b1;
	localparam logic KIND_ARR = 1'b0;

	// One result transaction.
	typedef struct packed {
		logic [DEPTH_W-1:0]  depth;
		logic [POS_W-1:0]    pos;
		logic [STATUS_W-1:0] status;
	} res_t;

	// Spelling of "true" (steps 0..3) and "false" without its f (steps 4..7).
	function automatic logic [7:0] lit_char(input logic [2:0] step);
		logic [7:0] c;
		case (step)
			3'd0: c = 8'h74;
			3'd1: c = 8'h72;
			3'd2: c = 8'h75;
			3'd3: c = 8'h65;
			3'd4: c = 8'h61;
			3'd5: c = 8'h6C;
			3'd6: c = 8'h73;
			3'd7: c = 8'h65;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/jsv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module jsv_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/jsv_front.sv @@
// Front end: accepts input transactions, classifies each byte and queues it for the parser.
module jsv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tlast,
	output logic                q_valid,
	output jsv_pkg::q_item_t    q_item,
	input  logic                q_pop
);

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	jsv_pkg::cls_t    cls;
	jsv_pkg::q_item_t slot_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             push;

	always_comb begin
		case (s_tdata) inside
			CH_TAB, CH_CR, CH_SPACE: cls = jsv_pkg::C_WS;
			CH_NL:                   cls = jsv_pkg::C_NL;
			CH_LBRACE:               cls = jsv_pkg::C_LBRACE;
			CH_LBRACK:               cls = jsv_pkg::C_LBRACK;
			CH_RBRACE:               cls = jsv_pkg::C_RBRACE;
			CH_RBRACK:               cls = jsv_pkg::C_RBRACK;
			CH_QUOTE:                cls = jsv_pkg::C_QUOTE;
			CH_COLON:                cls = jsv_pkg::C_COLON;
			CH_COMMA:                cls = jsv_pkg::C_COMMA;
			CH_DOT:                  cls = jsv_pkg::C_DOT;
			CH_BSLASH:               cls = jsv_pkg::C_BSLASH;
			CH_ZERO:                 cls = jsv_pkg::C_ZERO;
			[CH_ONE:CH_NINE]:        cls = jsv_pkg::C_DIGIT;
			CH_T:                    cls = jsv_pkg::C_T;
			CH_F:                    cls = jsv_pkg::C_F;
			default:                 cls = jsv_pkg::C_OTHER;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{ch: s_tdata, last: s_tlast, cls: cls};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

@@ rtl/jsv_back.sv @@
// Back end: the syntax state machine, nesting stack and result register.
module jsv_back #(
	parameter int MAX_NEST = 64,
	parameter int POS_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [6:0]             cfg_wdata,
	input  logic                   q_valid,
	input  jsv_pkg::q_item_t       q_item,
	output logic                   q_pop,
	output logic                   res_valid,
	input  logic                   res_ready,
	output jsv_pkg::res_t          res
);

	localparam int LVL_W = $clog2(MAX_NEST + 1);
	localparam int AW    = $clog2(MAX_NEST);
	localparam int CMP_W = (LVL_W > 7) ? LVL_W : 7;
	localparam int CNT_W = POS_BITS + 1;
	localparam logic [CNT_W-1:0] POS_LIMIT = CNT_W'(1) << POS_BITS;

	typedef enum logic [10:0] {
		M_START    = 11'b000_0000_0001,
		M_KEY_OPEN = 11'b000_0000_0010,
		M_KEY_STR  = 11'b000_0000_0100,
		M_COLON    = 11'b000_0000_1000,
		M_VALUE    = 11'b000_0001_0000,
		M_VAL_STR  = 11'b000_0010_0000,
		M_LIT      = 11'b000_0100_0000,
		M_INT      = 11'b000_1000_0000,
		M_FRAC     = 11'b001_0000_0000,
		M_AFTER    = 11'b010_0000_0000,
		M_DONE     = 11'b100_0000_0000
	} mode_t;

	mode_t            mode_q, mode_n, av_mode;
	logic [6:0]       max_depth_q;
	logic [LVL_W-1:0] level_q, level_n, lvl_next;
	logic [CNT_W-1:0] cnt_q, cnt_n, cnt1;
	logic             pb_q, pb_n;
	logic [2:0]       lit_q, lit_n;
	logic             err_q, err_n;
	logic             top_q, below_q, use_reg_q;
	logic             below, obj_top, room;
	logic             ok, push, push_obj, pop, av_ok, av_pop;
	logic             fire, apply, push_en, pop_en;
	logic             ws, digit;
	logic             ram_rdata;
	jsv_pkg::cls_t    cls;

	assign cls   = q_item.cls;
	assign ws    = (cls == jsv_pkg::C_WS) || (cls == jsv_pkg::C_NL);
	assign digit = (cls == jsv_pkg::C_ZERO) || (cls == jsv_pkg::C_DIGIT);

	// The kind of the open level lives in top_q; the one beneath comes from the RAM,
	// except right after a push, when the RAM read data does not yet hold the value just written.
	assign below   = use_reg_q ? below_q : ram_rdata;
	assign obj_top = (level_q != '0) && (top_q == jsv_pkg::KIND_OBJ);
	assign room    = (CMP_W'(level_q) < CMP_W'(max_depth_q)) && (level_q < LVL_W'(MAX_NEST));

	// Byte after a complete value: white space, separator or matching closer.
	always_comb begin
		av_ok   = 1'b0;
		av_pop  = 1'b0;
		av_mode = M_AFTER;
		if (ws) begin
			av_ok = 1'b1;
		end else if (cls == jsv_pkg::C_COMMA) begin
			av_ok   = 1'b1;
			av_mode = obj_top ? M_KEY_OPEN : M_VALUE;
		end else if ((cls == jsv_pkg::C_RBRACE && obj_top) ||
		             (cls == jsv_pkg::C_RBRACK && !obj_top)) begin
			av_ok   = 1'b1;
			av_pop  = (level_q != '0);
			av_mode = (level_q <= LVL_W'(1)) ? M_DONE : M_AFTER;
		end
	end

	always_comb begin
		ok       = 1'b0;
		mode_n   = mode_q;
		push     = 1'b0;
		push_obj = 1'b0;
		pop      = 1'b0;
		pb_n     = pb_q;
		lit_n    = lit_q;
		case (mode_q)
			M_START: begin
				if (ws) begin
					ok = 1'b1;
				end else if (cls == jsv_pkg::C_LBRACE) begin
					push     = 1'b1;
					push_obj = 1'b1;
				end else if (cls == jsv_pkg::C_LBRACK) begin
					push = 1'b1;
				end
			end
			M_KEY_OPEN: begin
				if (ws) begin
					ok = 1'b1;
				end else if (cls == jsv_pkg::C_QUOTE) begin
					ok     = 1'b1;
					pb_n   = 1'b0;
					mode_n = M_KEY_STR;
				end
			end
			M_KEY_STR, M_VAL_STR: begin
				if (cls != jsv_pkg::C_NL) begin
					ok = 1'b1;
					if (cls == jsv_pkg::C_QUOTE && !pb_q) begin
						mode_n = (mode_q == M_KEY_STR) ? M_COLON : M_AFTER;
					end else begin
						pb_n = (cls == jsv_pkg::C_BSLASH);
					end
				end
			end
			M_COLON: begin
				if (ws) begin
					ok = 1'b1;
				end else if (cls == jsv_pkg::C_COLON) begin
					ok     = 1'b1;
					mode_n = M_VALUE;
				end
			end
			M_VALUE: begin
				if (ws) begin
					ok = 1'b1;
				end else if (cls == jsv_pkg::C_LBRACE) begin
					push     = 1'b1;
					push_obj = 1'b1;
				end else if (cls == jsv_pkg::C_LBRACK) begin
					push = 1'b1;
				end else if (cls == jsv_pkg::C_QUOTE) begin
					ok     = 1'b1;
					pb_n   = 1'b0;
					mode_n = M_VAL_STR;
				end else if (cls == jsv_pkg::C_T || cls == jsv_pkg::C_F) begin
					ok     = 1'b1;
					lit_n  = (cls == jsv_pkg::C_T) ? 3'd1 : 3'd4;
					mode_n = M_LIT;
				end else if (cls == jsv_pkg::C_ZERO) begin
					ok     = 1'b1;
					mode_n = M_AFTER;
				end else if (cls == jsv_pkg::C_DIGIT) begin
					ok     = 1'b1;
					mode_n = M_INT;
				end
			end
			M_LIT: begin
				if (q_item.ch == jsv_pkg::lit_char(lit_q)) begin
					ok = 1'b1;
					if (lit_q == 3'd3 || lit_q == 3'd7) begin
						lit_n  = 3'd0;
						mode_n = M_AFTER;
					end else begin
						lit_n = lit_q + 3'd1;
					end
				end
			end
			M_INT: begin
				if (digit) begin
					ok = 1'b1;
				end else if (cls == jsv_pkg::C_DOT) begin
					ok     = 1'b1;
					mode_n = M_FRAC;
				end else begin
					ok     = av_ok;
					pop    = av_pop;
					mode_n = av_mode;
				end
			end
			M_FRAC: begin
				if (digit) begin
					ok = 1'b1;
				end else begin
					ok     = av_ok;
					pop    = av_pop;
					mode_n = av_mode;
				end
			end
			M_AFTER: begin
				ok     = av_ok;
				pop    = av_pop;
				mode_n = av_mode;
			end
			M_DONE: begin
				ok = ws;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (push) begin
			ok     = room;
			mode_n = push_obj ? M_KEY_OPEN : M_VALUE;
		end
	end

	assign fire    = q_valid && (!res_valid || res_ready);
	assign q_pop   = fire;
	assign apply   = !err_q && ok;
	assign push_en = apply && push;
	assign pop_en  = apply && pop;
	assign cnt1    = (cnt_q < POS_LIMIT) ? cnt_q + CNT_W'(1) : cnt_q;

	always_comb begin
		err_n = err_q;
		cnt_n = cnt_q;
		if (!err_q) begin
			cnt_n = cnt1;
			if (!ok) begin
				err_n = 1'b1;
			end else if (q_item.last && mode_n != M_DONE) begin
				// Document ended early: the position points one past its end.
				err_n = 1'b1;
				cnt_n = (cnt1 < POS_LIMIT) ? cnt1 + CNT_W'(1) : cnt1;
			end
		end
		level_n = level_q + LVL_W'(push_en) - LVL_W'(pop_en);
	end

	assign lvl_next = !fire ? level_q : (q_item.last ? '0 : level_n);

	jsv_ram #(
		.WIDTH(1),
		.DEPTH(MAX_NEST)
	) u_stack (
		.clk   (clk),
		.we    (fire && push_en && level_q != '0),
		.waddr (AW'(level_q - LVL_W'(1))),
		.wdata (top_q),
		.raddr (AW'(lvl_next - LVL_W'(2))),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (fire) begin
			res.status <= err_n ? jsv_pkg::ST_ERR :
			              (q_item.last ? jsv_pkg::ST_VALID : jsv_pkg::ST_PEND);
			res.pos    <= err_n ? jsv_pkg::POS_W'(cnt_n) : '0;
			res.depth  <= jsv_pkg::DEPTH_W'(level_n);
			if (push_en) begin
				top_q   <= push_obj;
				below_q <= top_q;
			end else if (pop_en) begin
				top_q <= below;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_START;
			level_q     <= '0;
			cnt_q       <= '0;
			pb_q        <= 1'b0;
			lit_q       <= 3'd0;
			err_q       <= 1'b0;
			use_reg_q   <= 1'b0;
			res_valid   <= 1'b0;
			max_depth_q <= 7'd64;
		end else begin
			if (cfg_we) begin
				max_depth_q <= cfg_wdata;
			end
			use_reg_q <= fire && push_en;
			if (fire) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
			if (fire) begin
				if (q_item.last) begin
					mode_q  <= M_START;
					level_q <= '0;
					cnt_q   <= '0;
					pb_q    <= 1'b0;
					lit_q   <= 3'd0;
					err_q   <= 1'b0;
				end else begin
					err_q   <= err_n;
					cnt_q   <= cnt_n;
					level_q <= level_n;
					if (apply) begin
						mode_q <= mode_n;
						pb_q   <= pb_n;
						lit_q  <= lit_n;
					end
				end
			end
		end
	end

endmodule

@@ rtl/json_syntax_validator.sv @@
// Each accepted byte is registered in the queue, and its result then in the result register.
// Throughput: one byte per cycle while the result register is not blocked; the parser state and
// the top-of-stack register feed back with no wait state, and the stack RAM read is registered and addressed ahead.
// The input stalls only when the two-entry queue is full behind a stalled output.
// Reset clears all control state and sets the depth limit to 64; the stack RAM needs no clearing.
// Top level of the JSON syntax validator.
module json_syntax_validator #(
	parameter int MAX_NEST = 64,
	parameter int POS_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,    // max_depth
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // ch
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata       // status[1:0], error_position[26:2], depth[33:27], zeros
);

	logic             q_valid;
	logic             q_pop;
	jsv_pkg::q_item_t q_item;
	jsv_pkg::res_t    res;

	jsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	jsv_back #(
		.MAX_NEST(MAX_NEST),
		.POS_BITS(POS_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {(jsv_pkg::TDATA_W - $bits(res))'(0), res};

	// An error position always counts at least one byte, so it is never zero.
	a_err_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status == jsv_pkg::ST_ERR |-> res.pos != '0)
		else $error("error result with zero position");

	// Pending and valid results carry no position.
	a_ok_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status != jsv_pkg::ST_ERR |-> res.pos == '0)
		else $error("position on a non-error result");

	// The parser takes a queued byte only when the result register can take its result.
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid && (!m_tvalid || m_tready))
		else $error("queue popped while the result register is blocked");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the JSON syntax validator: random documents, scoreboard, stalls.
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 60;
	localparam logic [6:0] DEPTH_SETTINGS [9] = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd0, 7'd3,
		7'd5, 7'd64, 7'd1};

	typedef logic [7:0] doc_t [$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = 7'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	int          cycles = 0;
	int          tx_idle = 0;
	int          rx_idle = 0;
	int          hold_reqs = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	logic [6:0]  cur_max = 7'd64;

	json_syntax_validator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Tracks the parser state of the current document and queues the verdict for each byte.
	class json_scoreboard;
		typedef enum logic [3:0] {
			AWAIT_ROOT, AWAIT_KEY, IN_KEY, AWAIT_COLON, AWAIT_VALUE, IN_STRING,
			IN_LITERAL, IN_INT, IN_FRAC, AFTER_VALUE, CLOSED
		} mode_t;

		mode_t          mode;
		logic           kinds [64];
		int unsigned    level;
		logic [24:0]    offset;
		bit             escaped;
		logic [2:0]     spell_idx;
		bit             latched;
		logic [6:0]     max_depth;
		logic [7:0]     spell [8];
		jsv_pkg::res_t  verdicts [$];
		int             fails;
		int             seen;

		function new();
			spell = '{"t", "r", "u", "e", "a", "l", "s", "e"};
			max_depth = 7'd64;
			fails = 0;
			seen = 0;
			clear_doc();
		endfunction

		function void clear_doc();
			mode = AWAIT_ROOT;
			level = 0;
			offset = 25'd0;
			escaped = 1'b0;
			spell_idx = 3'd0;
			latched = 1'b0;
		endfunction

		function bit is_ws(logic [7:0] c);
			return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
		endfunction

		function bit is_num(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit open_level(logic kind);
			int unsigned lim;
			lim = (max_depth < 64) ? max_depth : 64;
			if (level >= lim)
				return 1'b0;
			kinds[level] = kind;
			level++;
			if (kind == jsv_pkg::KIND_OBJ)
				mode = AWAIT_KEY;
			else
				mode = AWAIT_VALUE;
			return 1'b1;
		endfunction

		// Byte after a finished value: white space, a separator or the matching closer.
		function bit close_or_sep(logic [7:0] c);
			logic k;
			k = (level == 0) ? jsv_pkg::KIND_ARR : kinds[level-1];
			if (is_ws(c))
				return 1'b1;
			if (c == ",") begin
				if (k == jsv_pkg::KIND_OBJ)
					mode = AWAIT_KEY;
				else
					mode = AWAIT_VALUE;
				return 1'b1;
			end
			if ((c == "}" && k == jsv_pkg::KIND_OBJ) || (c == "]" && k == jsv_pkg::KIND_ARR)) begin
				if (level > 0)
					level--;
				if (level == 0)
					mode = CLOSED;
				else
					mode = AFTER_VALUE;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function bit string_in(logic [7:0] c, mode_t next);
			if (c == 8'h0A)
				return 1'b0;
			if (c == "\"" && !escaped) begin
				mode = next;
				return 1'b1;
			end
			escaped = (c == "\\");
			return 1'b1;
		endfunction

		function bit advance(logic [7:0] c);
			case (mode)
				AWAIT_ROOT: begin
					if (is_ws(c))
						return 1'b1;
					if (c == "{")
						return open_level(jsv_pkg::KIND_OBJ);
					if (c == "[")
						return open_level(jsv_pkg::KIND_ARR);
					return 1'b0;
				end
				AWAIT_KEY: begin
					if (is_ws(c))
						return 1'b1;
					if (c == "\"") begin
						escaped = 1'b0;
						mode = IN_KEY;
						return 1'b1;
					end
					return 1'b0;
				end
				IN_KEY: return string_in(c, AWAIT_COLON);
				AWAIT_COLON: begin
					if (is_ws(c))
						return 1'b1;
					if (c == ":") begin
						mode = AWAIT_VALUE;
						return 1'b1;
					end
					return 1'b0;
				end
				AWAIT_VALUE: begin
					if (is_ws(c))
						return 1'b1;
					if (c == "{")
						return open_level(jsv_pkg::KIND_OBJ);
					if (c == "[")
						return open_level(jsv_pkg::KIND_ARR);
					if (c == "\"") begin
						escaped = 1'b0;
						mode = IN_STRING;
						return 1'b1;
					end
					if (c == "t" || c == "f") begin
						spell_idx = (c == "t") ? 3'd1 : 3'd4;
						mode = IN_LITERAL;
						return 1'b1;
					end
					if (c == "0") begin
						mode = AFTER_VALUE;
						return 1'b1;
					end
					if (is_num(c)) begin
						mode = IN_INT;
						return 1'b1;
					end
					return 1'b0;
				end
				IN_STRING: return string_in(c, AFTER_VALUE);
				IN_LITERAL: begin
					if (spell[spell_idx] != c)
						return 1'b0;
					if (spell_idx == 3'd3 || spell_idx == 3'd7) begin
						spell_idx = 3'd0;
						mode = AFTER_VALUE;
					end else begin
						spell_idx = spell_idx + 3'd1;
					end
					return 1'b1;
				end
				IN_INT: begin
					if (is_num(c))
						return 1'b1;
					if (c == ".") begin
						mode = IN_FRAC;
						return 1'b1;
					end
					mode = AFTER_VALUE;
					return close_or_sep(c);
				end
				IN_FRAC: begin
					if (is_num(c))
						return 1'b1;
					mode = AFTER_VALUE;
					return close_or_sep(c);
				end
				AFTER_VALUE: return close_or_sep(c);
				CLOSED: return is_ws(c);
				default: return 1'b0;
			endcase
		endfunction

		function void note_byte(logic [7:0] c, logic last);
			jsv_pkg::res_t r;
			if (!latched) begin
				// Positions stop counting at two to the 24th.
				if (offset < 25'h1000000)
					offset++;
				if (!advance(c)) begin
					latched = 1'b1;
				end else if (last && mode != CLOSED) begin
					latched = 1'b1;
					if (offset < 25'h1000000)
						offset++;
				end
			end
			r.status = latched ? jsv_pkg::ST_ERR : (last ? jsv_pkg::ST_VALID : jsv_pkg::ST_PEND);
			r.pos = latched ? offset : 25'd0;
			r.depth = 7'(level);
			verdicts = {verdicts, r};
			if (last)
				clear_doc();
		endfunction

		task report(string msg);
			$display("mismatch at result %0d: %s", seen, msg);
			fails++;
		endtask

		task check_result(jsv_pkg::res_t got);
			jsv_pkg::res_t want;
			seen++;
			if (verdicts.size() == 0) begin
				report("result arrived with nothing outstanding");
				return;
			end
			want = verdicts.pop_front();
			if (got.status != want.status)
				report($sformatf("status %0d, wanted %0d", got.status, want.status));
			if (got.pos != want.pos)
				report($sformatf("error position %0d, wanted %0d", got.pos, want.pos));
			if (got.depth != want.depth)
				report($sformatf("depth %0d, wanted %0d", got.depth, want.depth));
		endtask
	endclass

	json_scoreboard sb;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Output side: random back-pressure, plus a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_byte(s_tdata, s_tlast);
		if (m_tvalid && m_tready)
			sb.check_result(jsv_pkg::res_t'(m_tdata[33:0]));
	end

	task send_byte(logic [7:0] b, logic l);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
	endtask

	task send_doc(doc_t d);
		for (int i = 0; i < d.size(); i++)
			send_byte(d[i], i == d.size() - 1);
	endtask

	task send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	// Stops offering bytes and waits until every transaction sent so far has its result back.
	task drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.verdicts.size() != 0);
	endtask

	task set_max_depth(logic [6:0] v);
		drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.max_depth = v;
		cur_max = v;
	endtask

	task automatic append_byte(ref doc_t d, input logic [7:0] b);
		d = {d, b};
	endtask

	task automatic add_ws(ref doc_t d);
		logic [7:0] ws [4];
		ws = '{8'h20, 8'h09, 8'h0A, 8'h0D};
		if ($urandom_range(99) < 15)
			append_byte(d, ws[$urandom_range(3)]);
	endtask

	task automatic add_string(ref doc_t d);
		logic [7:0] b;
		append_byte(d, "\"");
		repeat ($urandom_range(4)) begin
			case ($urandom_range(9))
				0: append_byte(d, "\\");
				1: begin
					append_byte(d, "\\");
					append_byte(d, "\"");
				end
				2, 3: begin
					b = 8'($urandom_range(255));
					if (b == 8'h0A || b == "\"")
						b = "A";
					append_byte(d, b);
				end
				default: begin
					b = 8'($urandom_range(126, 32));
					if (b == "\"")
						b = "a";
					append_byte(d, b);
				end
			endcase
		end
		// A backslash right before the closing quote would keep the string open.
		if (d[$] == "\\")
			append_byte(d, "x");
		append_byte(d, "\"");
	endtask

	task automatic add_scalar(ref doc_t d);
		string word;
		case ($urandom_range(5))
			0: add_string(d);
			1, 2: begin
				if ($urandom_range(1))
					word = "true";
				else
					word = "false";
				for (int i = 0; i < word.len(); i++)
					append_byte(d, word[i]);
			end
			3: append_byte(d, "0");
			default: begin
				append_byte(d, 8'($urandom_range(57, 49)));
				repeat ($urandom_range(3))
					append_byte(d, 8'($urandom_range(57, 48)));
				if ($urandom_range(1)) begin
					append_byte(d, ".");
					repeat ($urandom_range(3))
						append_byte(d, 8'($urandom_range(57, 48)));
				end
			end
		endcase
	endtask

	// Mostly well-formed documents of random shape, some damaged, a few pure noise.
	task automatic make_doc(ref doc_t d);
		int unsigned lim, target, budget, sp, pick, p_open, k;
		logic        obj [80];
		int unsigned items [80];
		d = {};
		pick = $urandom_range(99);
		if (pick < 5) begin
			repeat ($urandom_range(8, 1))
				append_byte(d, 8'($urandom_range(255)));
			return;
		end
		lim = (cur_max > 64) ? 64 : cur_max;
		pick = $urandom_range(99);
		if (lim == 0)
			target = 1;
		else if (pick < 60)
			target = $urandom_range((lim < 3) ? lim : 3, 1);
		else if (pick < 80)
			target = $urandom_range((lim < 8) ? lim : 8, 1);
		else if (pick < 92)
			target = lim;
		else
			target = lim + 1;
		p_open = (pick >= 80) ? 100 : 50;
		budget = 24 + 3 * target;
		add_ws(d);
		obj[0] = 1'($urandom_range(1));
		append_byte(d, obj[0] ? 8'h7B : 8'h5B);
		items[0] = 0;
		sp = 1;
		while (sp > 0) begin
			add_ws(d);
			if (items[sp-1] > 0 && (d.size() > budget || $urandom_range(99) < 40)) begin
				append_byte(d, obj[sp-1] ? 8'h7D : 8'h5D);
				sp--;
			end else begin
				if (items[sp-1] > 0) begin
					append_byte(d, ",");
					add_ws(d);
				end
				if (obj[sp-1]) begin
					add_string(d);
					add_ws(d);
					append_byte(d, ":");
					add_ws(d);
				end
				items[sp-1]++;
				if (sp < target && $urandom_range(99) < p_open) begin
					obj[sp] = 1'($urandom_range(1));
					append_byte(d, obj[sp] ? 8'h7B : 8'h5B);
					items[sp] = 0;
					sp++;
				end else begin
					add_scalar(d);
				end
			end
		end
		add_ws(d);
		pick = $urandom_range(99);
		if (pick < 10) begin
			d[$urandom_range(d.size() - 1)] = 8'($urandom_range(255));
		end else if (pick < 20 && d.size() > 1) begin
			k = $urandom_range(d.size() - 1, 1);
			repeat (d.size() - k)
				void'(d.pop_back());
		end else if (pick < 25) begin
			append_byte(d, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		doc_t        d;
		int unsigned sent;
		bit          first;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 7;
		rx_idle <= 73;
		send_text("[0]");
		// Two backslashes still escape the quote, so the document ends inside the key.
		send_text("\n{\"\\\\\"}");
		send_text("[1.,false]\t");
		d = '{8'h5B, 8'hFF, 8'h5D};
		send_doc(d);
		d = '{8'h00};
		send_doc(d);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 7 : ((ph == 1) ? 73 : 0);
			rx_idle <= (ph == 0) ? 73 : ((ph == 1) ? 7 : 0);
			for (int s = 0; s < 3; s++) begin
				set_max_depth(DEPTH_SETTINGS[ph * 3 + s]);
				sent = 0;
				first = 1'b1;
				while (sent < 75) begin
					make_doc(d);
					send_doc(d);
					sent += d.size();
					if (first && s == 0)
						hold_reqs <= hold_reqs + 1;
					else if (first && s == 1)
						drain();
					first = 1'b0;
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/jsv_pkg.sv
rtl/jsv_ram.sv
rtl/jsv_front.sv
rtl/jsv_back.sv
rtl/json_syntax_validator.sv
sim/testbench.sv
